>>> design/mhpq_pkg.sv
package mhpq_pkg;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] key;
      logic [15:0] row;
      logic [15:0] column;
      logic [15:0] tag;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key;
      logic [15:0] row;
      logic [15:0] column;
      logic [15:0] tag;
      logic [6:0]  count;
   } rsp_type;

endpackage

>>> design/mhpq_ram.sv
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   // registered address and registered data: rd_addr is captured in rd_addr_ff, then the word in rd_data_ff
   logic [WIDTH-1:0]         mem_ff [DEPTH];
   logic [$clog2(DEPTH)-1:0] rd_addr_ff;
   logic [WIDTH-1:0]         rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_addr_ff <= rd_addr;
      rd_data_ff <= mem_ff[rd_addr_ff];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mhpq_front.sv
// front: accepts requests into a two-entry queue
module mhpq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mhpq_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_ready,
   output mhpq_pkg::cmd_type q_cmd
);

   mhpq_pkg::cmd_type slot_ff [2];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   assign in_ready = (fill_ff != 2'd2);
   assign q_valid  = (fill_ff != 2'd0);
   assign q_cmd    = slot_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_cmd;
      end
   end

endmodule

>>> design/mhpq_back.sv
// back: heap update and full bottom-up rebuild over the entry ram
module mhpq_back #(
   parameter int CAPACITY   = 64,
   parameter int INDEX_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  mhpq_pkg::cmd_type q_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output mhpq_pkg::rsp_type out_rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam int EW = 32 + 3 * PW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RROOT = 4'd1;
   localparam logic [3:0] ST_WROOT = 4'd2;
   localparam logic [3:0] ST_RLAST = 4'd3;
   localparam logic [3:0] ST_NEXT  = 4'd4;
   localparam logic [3:0] ST_RNODE = 4'd5;
   localparam logic [3:0] ST_RLEFT = 4'd6;
   localparam logic [3:0] ST_RRGT  = 4'd7;
   localparam logic [3:0] ST_CMP   = 4'd8;
   localparam logic [3:0] ST_SWAP  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam logic [3:0] ST_WAIT1 = 4'd11;
   localparam logic [3:0] ST_WAIT2 = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       outer_ff, outer_in;   // next sift start + 1
   logic [CW:0]         node_ff, node_in;
   logic [CW:0]         best_ff, best_in;
   logic [EW-1:0]       node_e_ff, node_e_in, best_e_ff, best_e_in;
   mhpq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                valid_ff, valid_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [EW-1:0]       wr_data, rd_data;
   logic [CW:0]         left, right;
   logic                lt;

   mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign left      = {node_ff[CW-1:0], 1'b1};
   assign right     = left + {{CW{1'b0}}, 1'b1};
   assign lt        = $signed(rd_data[EW-1 -: 32]) < $signed(best_e_ff[EW-1 -: 32]);
   assign q_ready   = (state_ff == ST_IDLE) && !valid_ff;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      outer_in  = outer_ff;
      node_in   = node_ff;
      best_in   = best_ff;
      node_e_in = node_e_ff;
      best_e_in = best_e_ff;
      rsp_in    = rsp_ff;
      valid_in  = valid_ff && !out_ready;
      wr_en     = 1'b0;
      wr_addr   = node_ff[AW-1:0];
      wr_data   = node_e_ff;
      rd_addr   = node_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_ready) begin
               rsp_in        = '0;
               rsp_in.count  = 7'(count_ff);
               if (q_cmd.op == mhpq_pkg::REQ_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     rsp_in.status = mhpq_pkg::STATUS_FULL;
                     state_in      = ST_OUT;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = {q_cmd.key, q_cmd.row[PW-1:0], q_cmd.column[PW-1:0],
                                 q_cmd.tag[PW-1:0]};
                     count_in = count_ff + 1'b1;
                     outer_in = (count_ff + 1'b1) >> 1;
                     rsp_in.count = 7'(count_ff + 1'b1);
                     state_in = ST_NEXT;
                  end
               end else if (count_ff == '0) begin
                  rsp_in.status = mhpq_pkg::STATUS_EMPTY;
                  state_in      = ST_OUT;
               end else begin
                  rd_addr  = '0;
                  state_in = ST_RROOT;
               end
            end
         end
         ST_RROOT: begin
            rd_addr  = AW'(count_ff - 1'b1);
            state_in = ST_RLAST;
         end
         ST_RLAST: begin
            // root data arrives; hold it while the read of the last entry, issued in ST_RROOT, completes
            node_e_in      = rd_data;
            rsp_in.key     = rd_data[EW-1 -: 32];
            rsp_in.row     = 16'(rd_data[3*PW-1 -: PW]);
            rsp_in.column  = 16'(rd_data[2*PW-1 -: PW]);
            rsp_in.tag     = 16'(rd_data[PW-1:0]);
            state_in       = ST_WROOT;
         end
         ST_WROOT: begin
            // rd_data holds last entry; swap root and last
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = rd_data;
            best_e_in = node_e_ff;
            best_in  = {1'b0, count_ff - 1'b1};
            count_in = count_ff - 1'b1;
            outer_in = (count_ff - 1'b1) >> 1;
            rsp_in.count = 7'(count_ff - 1'b1);
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff[AW-1:0];
            wr_data  = best_e_ff;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (outer_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               node_in  = {1'b0, outer_ff - 1'b1};
               outer_in = outer_ff - 1'b1;
               rd_addr  = AW'(outer_ff - 1'b1);
               state_in = ST_RNODE;
            end
         end
         ST_RNODE: begin
            // node data next cycle; issue left read
            rd_addr  = left[AW-1:0];
            state_in = ST_RLEFT;
         end
         ST_RLEFT: begin
            node_e_in = rd_data;
            best_e_in = rd_data;
            best_in   = node_ff;
            rd_addr   = right[AW-1:0];
            state_in  = ST_RRGT;
         end
         ST_RRGT: begin
            // left data
            if (left < {1'b0, count_ff} && lt) begin
               best_in   = left;
               best_e_in = rd_data;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // right data
            if (right < {1'b0, count_ff} && lt) begin
               best_in   = right;
               best_e_in = rd_data;
               state_in  = ST_SWAP;
            end else if (best_ff != node_ff) begin
               state_in  = ST_SWAP;
            end else begin
               state_in  = ST_NEXT;
            end
         end
         ST_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff[AW-1:0];
            wr_data  = best_e_ff;
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            // moved node entry goes to the child slot, continue from there
            wr_en     = 1'b1;
            wr_addr   = best_ff[AW-1:0];
            wr_data   = node_e_ff;
            node_in   = best_ff;
            best_e_in = node_e_ff;
            rd_addr   = best_ff[AW-1:0];
            state_in  = ST_RNODE;
         end
         ST_OUT: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      outer_ff  <= outer_in;
      node_ff   <= node_in;
      best_ff   <= best_in;
      node_e_ff <= node_e_in;
      best_e_ff <= best_e_in;
      rsp_ff    <= rsp_in;
   end

endmodule

>>> design/min_heap_priority_queue_top.sv
// min-heap priority queue, one response transfer per request transfer
// flagged requests (insert on full, pop on empty) skip the entry ram; other requests
// respond after a bottom-up rebuild over every internal node of the entry ram
// throughput: one request at a time, set by the bottom-up rebuild loop
// reset: synchronous, empties the heap; entry storage is not cleared
module min_heap_priority_queue_top #(
   parameter int CAPACITY   = 64,
   parameter int INDEX_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // key[31:0], row, column, tag
   input  logic         req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // status[1:0], out_key, out_row, out_column,
                                     // out_tag, count[6:0], zero fill
   output logic         rsp_tuser
);

   mhpq_pkg::cmd_type in_cmd, q_cmd;
   mhpq_pkg::rsp_type rsp;
   logic              q_valid, q_ready;

   // unpack request transfer
   assign in_cmd.op     = req_tuser;
   assign in_cmd.key    = req_tdata[31:0];
   assign in_cmd.row    = req_tdata[47:32];
   assign in_cmd.column = req_tdata[63:48];
   assign in_cmd.tag    = req_tdata[79:64];

   mhpq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_cmd  (in_cmd),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_cmd   (q_cmd)
   );

   mhpq_back #(.CAPACITY(CAPACITY), .INDEX_BITS(INDEX_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_rsp  (rsp)
   );

   // pack response transfer
   assign rsp_tdata = {7'd0, rsp.count, rsp.tag, rsp.column, rsp.row, rsp.key, rsp.status};
   assign rsp_tuser = 1'b0;

endmodule

>>> tb/tb_top.sv
module tb_top;

   localparam int HEAP_DEPTH = 64;

   // one predicted response transfer
   typedef struct {
      logic [1:0]  status;
      logic [31:0] key;
      logic [15:0] row;
      logic [15:0] column;
      logic [15:0] tag;
      logic [6:0]  count;
   } heap_rsp_type;

   // predictor of the heap plus queue of pending responses
   class heap_scoreboard;
      logic [31:0]  keys [HEAP_DEPTH];
      logic [15:0]  rows [HEAP_DEPTH];
      logic [15:0]  cols [HEAP_DEPTH];
      logic [15:0]  tags [HEAP_DEPTH];
      int           fill;
      heap_rsp_type pending_rsp[$];
      int           mismatches;
      int           checked;
      int           pops_ok, pops_empty, drops;

      function void swap_slots(int a, int b);
         logic [31:0] k;
         logic [15:0] r, c, t;
         k = keys[a]; keys[a] = keys[b]; keys[b] = k;
         r = rows[a]; rows[a] = rows[b]; rows[b] = r;
         c = cols[a]; cols[a] = cols[b]; cols[b] = c;
         t = tags[a]; tags[a] = tags[b]; tags[b] = t;
      endfunction

      function void sift(int n, int node);
         int l, r, best;
         forever begin
            l = 2 * node + 1;
            r = 2 * node + 2;
            best = node;
            if (l < n && $signed(keys[l]) < $signed(keys[best])) best = l;
            if (r < n && $signed(keys[r]) < $signed(keys[best])) best = r;
            if (best == node) return;
            swap_slots(node, best);
            node = best;
         end
      endfunction

      function void heapify(int n);
         for (int i = n / 2 - 1; i >= 0; i--) sift(n, i);
      endfunction

      // note an accepted request and queue the response it causes
      function void note_request(logic op, logic [79:0] data);
         heap_rsp_type e;
         e = '{mhpq_pkg::STATUS_OK, 32'd0, 16'd0, 16'd0, 16'd0, 7'd0};
         if (op == mhpq_pkg::REQ_INSERT) begin
            if (fill >= HEAP_DEPTH) begin
               e.status = mhpq_pkg::STATUS_FULL;
               drops++;
            end else begin
               keys[fill] = data[31:0];
               rows[fill] = data[47:32];
               cols[fill] = data[63:48];
               tags[fill] = data[79:64];
               fill++;
               heapify(fill);
            end
         end else begin
            if (fill == 0) begin
               e.status = mhpq_pkg::STATUS_EMPTY;
               pops_empty++;
            end else begin
               e.key = keys[0];
               e.row = rows[0];
               e.column = cols[0];
               e.tag = tags[0];
               swap_slots(0, fill - 1);
               fill--;
               heapify(fill);
               pops_ok++;
            end
         end
         e.count = fill[6:0];
         pending_rsp.push_back(e);
      endfunction

      // compare one response transfer with the oldest prediction
      function void check_response(logic [95:0] d);
         heap_rsp_type e;
         heap_rsp_type a;
         a.status = d[1:0];
         a.key    = d[33:2];
         a.row    = d[49:34];
         a.column = d[65:50];
         a.tag    = d[81:66];
         a.count  = d[88:82];
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", d);
            return;
         end
         e = pending_rsp.pop_front();
         if (a.status !== e.status || a.key !== e.key || a.row !== e.row ||
             a.column !== e.column || a.tag !== e.tag || a.count !== e.count ||
             d[95:89] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d: exp st=%0d key=%h r=%h c=%h t=%h n=%0d",
                        checked, e.status, e.key, e.row, e.column, e.tag, e.count);
               $display("   got st=%0d key=%h r=%h c=%h t=%h n=%0d",
                        a.status, a.key, a.row, a.column, a.tag, a.count);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;   // key[31:0], row, column, tag
   logic         req_tuser;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // status, out_key, out_row, out_column, out_tag, count
   logic         rsp_tuser;

   heap_scoreboard board;
   bit             rx_quiet;     // no random stalls on the response side
   bit             long_hold;    // response side held off for a long stretch
   int             sent;

   min_heap_priority_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // offer one request and hold it until the transfer happens
   task automatic send_request(logic op, logic [31:0] key, logic [15:0] row,
                               logic [15:0] col, logic [15:0] tag, bit gaps);
      int idle;
      if (gaps && $urandom_range(0, 3) == 0) begin
         idle = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {tag, col, row, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, {tag, col, row, key});
      sent++;
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pause until every predicted response has arrived
   task automatic drain();
      drop_valid();
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) - 4;  // heavy ties around zero
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request(bit gaps, int pop_weight);
      logic op;
      op = ($urandom_range(0, 99) < pop_weight) ? mhpq_pkg::REQ_POP : mhpq_pkg::REQ_INSERT;
      send_request(op, pick_key(), 16'($urandom), 16'($urandom), 16'($urandom), gaps);
   endtask

   // response side: random stalls, long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold) begin
         rsp_tready <= 1'b0;
      end else if (rx_quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   // stimulus
   initial begin
      board = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= mhpq_pkg::REQ_INSERT;
      rx_quiet   = 1'b0;
      long_hold  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pop on empty, field extremes, equal keys
      send_request(mhpq_pkg::REQ_POP, 32'h0, 16'h0, 16'h0, 16'h0, 0);
      send_request(mhpq_pkg::REQ_INSERT, 32'h7fff_ffff, 16'hffff, 16'hffff, 16'hffff, 0);
      send_request(mhpq_pkg::REQ_INSERT, 32'h8000_0000, 16'h0000, 16'h0000, 16'h0000, 0);
      send_request(mhpq_pkg::REQ_INSERT, 32'h0001_0000, 16'h1111, 16'h2222, 16'h3333, 0);
      send_request(mhpq_pkg::REQ_INSERT, 32'h0001_0000, 16'h4444, 16'h5555, 16'h6666, 0);
      send_request(mhpq_pkg::REQ_INSERT, 32'hffff_ffff, 16'haaaa, 16'h5555, 16'ha5a5, 0);
      repeat (6)
         send_request(mhpq_pkg::REQ_POP, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 0);
      drain();

      // fill to capacity with the receiver held off, then insert on full
      fork
         begin
            long_hold = 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
      join_none
      for (int i = 0; i < HEAP_DEPTH + 3; i++)
         send_request(mhpq_pkg::REQ_INSERT, (i % 5 == 0) ? 32'd7 : pick_key(),
                      16'($urandom), 16'($urandom), 16'($urandom), 0);
      drain();
      for (int i = 0; i < HEAP_DEPTH + 2; i++) random_request(1, 100);
      drain();

      // random: swings between filling and emptying phases
      for (int i = 0; i < 900; i++) begin
         if (i == 750) rx_quiet = 1'b1;
         random_request(i < 750, ((i / 100) % 2) ? 70 : 30);
      end
      drain();
      repeat (400) @(posedge clock);

      $display("covered %0d requests: %0d pops with data, %0d pops on empty,",
               sent, board.pops_ok, board.pops_empty);
      $display("   %0d dropped inserts on a full heap, long receiver hold and drains",
               board.drops);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> min_heap_priority_queue_top.f
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/mhpq_front.sv
design/mhpq_back.sv
design/min_heap_priority_queue_top.sv
tb/tb_top.sv
